>>> rtl/core/dlr_pkg.sv
package dlr_pkg;

  localparam int unsigned COORD_W   = 16;
  localparam int unsigned DIFF_W    = COORD_W + 1;
  localparam int unsigned MAG_W     = 16;
  localparam int unsigned COLOR_W   = 32;
  localparam int unsigned CANVAS_W  = 13;
  localparam int unsigned XY_W      = 14;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned S_TDATA_W = 4 * COORD_W + COLOR_W;
  localparam int unsigned M_TDATA_W = 64;

  localparam logic [CANVAS_W-1:0] CANVAS_WIDTH_RESET  = 13'd640;
  localparam logic [CANVAS_W-1:0] CANVAS_HEIGHT_RESET = 13'd480;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CANVAS_WIDTH,
    REG_CANVAS_HEIGHT
  } cfg_reg_e;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] num;
    logic [MAG_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic                   in_canvas;
  } pixel_t;

endpackage

>>> rtl/core/dlr_divider.sv
module dlr_divider #(
  parameter int unsigned Q_W = 17
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dlr_pkg::div_req_t req_i,
  output logic              done_o,
  output logic [Q_W-1:0]    quot_o
);
  import dlr_pkg::*;

  localparam int unsigned CNT_W = $clog2(Q_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(Q_W - 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [MAG_W:0]   rem_q;
  logic [MAG_W-1:0] den_q;
  logic [Q_W-1:0]   quot_q;

  logic             ge;
  logic [MAG_W:0]   rem_sub;
  logic [MAG_W-1:0] rem_next;

  // One restoring compare-and-subtract step per cycle, integer bit first.
  assign ge       = rem_q >= {1'b0, den_q};
  assign rem_sub  = rem_q - {1'b0, den_q};
  assign rem_next = ge ? rem_sub[MAG_W-1:0] : rem_q[MAG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= {1'b0, req_i.num};
        den_q  <= req_i.den;
      end else if (busy_q) begin
        quot_q <= {quot_q[Q_W-2:0], ge};
        rem_q  <= {rem_next, 1'b0};
        cnt_q  <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.start |=> busy_q)
    else $error("Divider did not start on request.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q < {den_q, 1'b0})
    else $error("Partial remainder out of range.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("Divider reports done while busy.");
`endif

endmodule

>>> rtl/core/dlr_pixel.sv
module dlr_pixel #(
  parameter int unsigned MAJ_W           = 12,
  parameter int unsigned ACC_W           = 31,
  parameter int unsigned SLOPE_FRAC_BITS = 16
) (
  input  logic                          along_y_i,
  input  logic signed [MAJ_W-1:0]       counter_i,
  input  logic signed [ACC_W-1:0]       accum_i,
  input  logic [dlr_pkg::CANVAS_W-1:0]  width_i,
  input  logic [dlr_pkg::CANVAS_W-1:0]  height_i,
  output dlr_pkg::pixel_t               pixel_o
);
  import dlr_pkg::*;

  localparam int unsigned HW_FX_W = SLOPE_FRAC_BITS + CANVAS_W;
  localparam int unsigned SUM_W   = ((ACC_W > HW_FX_W) ? ACC_W : HW_FX_W) + 1;
  localparam int unsigned MINT_W  = SUM_W - SLOPE_FRAC_BITS;
  localparam int unsigned MJ_W    = ((MAJ_W > CANVAS_W) ? MAJ_W : CANVAS_W) + 1;
  localparam int unsigned INT_W   = (MINT_W > MJ_W) ? MINT_W : MJ_W;

  localparam logic signed [SUM_W-1:0] FX_RND = SUM_W'((1 << SLOPE_FRAC_BITS) - 1);
  localparam logic signed [INT_W-1:0] XY_MAX = INT_W'((2 ** (XY_W - 1)) - 1);
  localparam logic signed [INT_W-1:0] XY_MIN = INT_W'(-(2 ** (XY_W - 1)));

  logic [CANVAS_W-2:0]      hw, hh;
  logic signed [SUM_W-1:0]  hw_fx, hh_fx, acc_x, msum, msum_adj;
  logic signed [INT_W-1:0]  mint, mj, cnt_x, hw_i, hh_i, wid_i, hei_i;
  logic signed [INT_W-1:0]  bx, by, x_sat, y_sat;

  assign hw    = width_i[CANVAS_W-1:1];
  assign hh    = height_i[CANVAS_W-1:1];
  assign hw_fx = SUM_W'(hw) << SLOPE_FRAC_BITS;
  assign hh_fx = SUM_W'(hh) << SLOPE_FRAC_BITS;
  assign acc_x = SUM_W'(accum_i);
  assign cnt_x = INT_W'(counter_i);
  assign hw_i  = INT_W'(hw);
  assign hh_i  = INT_W'(hh);
  assign wid_i = INT_W'(width_i);
  assign hei_i = INT_W'(height_i);

  // The minor coordinate is truncated toward zero.
  assign msum     = along_y_i ? (acc_x + hw_fx) : (hh_fx - acc_x);
  assign msum_adj = msum + (msum[SUM_W-1] ? FX_RND : '0);
  assign mint     = INT_W'(msum_adj >>> SLOPE_FRAC_BITS);
  assign mj       = along_y_i ? (hh_i - cnt_x) : (cnt_x + hw_i);

  assign bx = along_y_i ? mint : mj;
  assign by = along_y_i ? mj : mint;

  assign x_sat = (bx > XY_MAX) ? XY_MAX : ((bx < XY_MIN) ? XY_MIN : bx);
  assign y_sat = (by > XY_MAX) ? XY_MAX : ((by < XY_MIN) ? XY_MIN : by);

  assign pixel_o.x         = XY_W'(x_sat);
  assign pixel_o.y         = XY_W'(y_sat);
  assign pixel_o.in_canvas = !bx[INT_W-1] && (bx < wid_i) && !by[INT_W-1] && (by < hei_i);

endmodule

>>> rtl/core/dda_line_rasterizer_unit.sv
// Line rasterizer using a digital differential analyzer.
// Requests arrive on the s_axis channel; tuser selects start (0) or step (1).
// A start request carries both endpoints (signed, centred, y-up, fixed point)
// and the line color. It produces no pixel and drops any line in progress.
// Each step request emits the next pixel of the active line on m_axis, or
// nothing when no line is active. tlast marks the final pixel of a line and
// tuser flags a pixel that lies inside the configured bitmap.
// The cfg channel writes the bitmap width and height; it is always ready.
// A step request's pixel is registered on m_axis.
// A start request keeps s_axis_tready low through the axis, order, setup and
// check states and, unless the slope is zero or saturated, while the restoring
// divider retires one quotient bit per cycle. While a pixel waits on a stalled
// m_axis, the next request is held off until the pixel is taken.
// Reset sets the bitmap to 640 by 480, clears the output valid flag and leaves
// no line active.
module dda_line_rasterizer_unit #(
  parameter int unsigned COORD_FRAC_BITS = 4,
  parameter int unsigned SLOPE_FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dlr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [dlr_pkg::CANVAS_W-1:0]    cfg_data_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // x_start, y_start, x_end, y_end, pixel_color
  input  logic [dlr_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  // req_type
  input  logic                            s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // out_x, out_y, out_color, zero fill
  output logic [dlr_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,
  // in_canvas
  output logic                            m_axis_tuser_o,
  output logic                            m_axis_tlast_o
);
  import dlr_pkg::*;

  localparam int unsigned MAJ_W  = COORD_W - COORD_FRAC_BITS;
  localparam int unsigned ACC_W  = SLOPE_FRAC_BITS - COORD_FRAC_BITS + 19;
  localparam int unsigned SL_W   = SLOPE_FRAC_BITS + 3;
  localparam int unsigned Q_W    = SLOPE_FRAC_BITS + 1;
  localparam int unsigned ACC_SH = SLOPE_FRAC_BITS - COORD_FRAC_BITS;
  localparam int unsigned PAD_W  = M_TDATA_W - 2 * XY_W - COLOR_W;

  localparam logic signed [SL_W-1:0]   SLOPE_MAX = SL_W'(1 << (SLOPE_FRAC_BITS + 1));
  localparam logic signed [DIFF_W-1:0] CF_RND    = DIFF_W'((1 << COORD_FRAC_BITS) - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_AXIS,
    S_ORDER,
    S_SETUP,
    S_CHECK,
    S_DIV
  } state_e;

  state_e                    state_q;
  logic [CANVAS_W-1:0]       width_q, height_q;
  logic signed [COORD_W-1:0] p0x_q, p0y_q, p1x_q, p1y_q;
  logic signed [COORD_W-1:0] maj0_q, maj1_q, min0_q, min1_q;
  logic                      along_y_q;
  logic [MAG_W-1:0]          den_q, mag_q;
  logic                      neg_q;
  logic signed [MAJ_W-1:0]   counter_q, limit_q;
  logic signed [ACC_W-1:0]   accum_q;
  logic signed [SL_W-1:0]    slope_q;
  logic [COLOR_W-1:0]        color_q;
  logic                      active_q;

  logic                      out_valid_q;
  logic signed [XY_W-1:0]    out_x_q, out_y_q;
  logic [COLOR_W-1:0]        out_color_q;
  logic                      out_in_q, out_last_q;

  logic                      s_accept;
  logic                      out_load;
  logic signed [DIFF_W-1:0]  dx, dy, dmaj, dmin, maj0_adj;
  logic [DIFF_W-1:0]         dx_abs, dy_abs, dmin_abs;
  logic [MAG_W-1:0]          adx, ady;
  logic                      along_y_d;
  logic                      slope_sat, last_pix, line_ok;
  logic signed [SL_W-1:0]    quot_signed;
  div_req_t                  div_req;
  logic                      div_done;
  logic [Q_W-1:0]            div_quot;
  pixel_t                    pix;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load        = s_accept && (s_axis_tuser_i == REQ_STEP) && active_q;

  // Axis choice on truncated absolute differences.
  assign dx        = DIFF_W'(p1x_q) - DIFF_W'(p0x_q);
  assign dy        = DIFF_W'(p1y_q) - DIFF_W'(p0y_q);
  assign dx_abs    = dx[DIFF_W-1] ? -dx : dx;
  assign dy_abs    = dy[DIFF_W-1] ? -dy : dy;
  assign adx       = MAG_W'(dx_abs >> COORD_FRAC_BITS);
  assign ady       = MAG_W'(dy_abs >> COORD_FRAC_BITS);
  assign along_y_d = !(adx > ady);

  assign dmaj     = DIFF_W'(maj1_q) - DIFF_W'(maj0_q);
  assign dmin     = DIFF_W'(min1_q) - DIFF_W'(min0_q);
  assign dmin_abs = dmin[DIFF_W-1] ? -dmin : dmin;
  assign maj0_adj = DIFF_W'(maj0_q) + (maj0_q[COORD_W-1] ? CF_RND : '0);

  assign slope_sat   = {1'b0, mag_q} >= {den_q, 1'b0};
  assign quot_signed = neg_q ? -SL_W'(div_quot) : SL_W'(div_quot);
  assign last_pix    = counter_q >= limit_q;
  assign line_ok     = counter_q <= limit_q;

  assign div_req.start = (state_q == S_CHECK) && (den_q != '0) && !slope_sat;
  assign div_req.num   = mag_q;
  assign div_req.den   = den_q;

  dlr_divider #(
    .Q_W (Q_W)
  ) u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  dlr_pixel #(
    .MAJ_W           (MAJ_W),
    .ACC_W           (ACC_W),
    .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS)
  ) u_pixel (
    .along_y_i (along_y_q),
    .counter_i (counter_q),
    .accum_i   (accum_q),
    .width_i   (width_q),
    .height_i  (height_q),
    .pixel_o   (pix)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      width_q     <= CANVAS_WIDTH_RESET;
      height_q    <= CANVAS_HEIGHT_RESET;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_CANVAS_WIDTH:  width_q  <= cfg_data_i;
          REG_CANVAS_HEIGHT: height_q <= cfg_data_i;
          default:           width_q  <= width_q;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_accept) begin
            if (s_axis_tuser_i == REQ_START) begin
              p0x_q    <= s_axis_tdata_i[COORD_W-1:0];
              p0y_q    <= s_axis_tdata_i[2*COORD_W-1:COORD_W];
              p1x_q    <= s_axis_tdata_i[3*COORD_W-1:2*COORD_W];
              p1y_q    <= s_axis_tdata_i[4*COORD_W-1:3*COORD_W];
              color_q  <= s_axis_tdata_i[4*COORD_W +: COLOR_W];
              active_q <= 1'b0;
              state_q  <= S_AXIS;
            end else if (active_q) begin
              out_x_q     <= pix.x;
              out_y_q     <= pix.y;
              out_in_q    <= pix.in_canvas;
              out_color_q <= color_q;
              out_last_q  <= last_pix;
              if (last_pix) begin
                active_q <= 1'b0;
              end else begin
                counter_q <= counter_q + MAJ_W'(1);
                accum_q   <= accum_q + ACC_W'(slope_q);
              end
            end
          end
        end
        S_AXIS: begin
          along_y_q <= along_y_d;
          maj0_q    <= along_y_d ? p0y_q : p0x_q;
          maj1_q    <= along_y_d ? p1y_q : p1x_q;
          min0_q    <= along_y_d ? p0x_q : p0y_q;
          min1_q    <= along_y_d ? p1x_q : p1y_q;
          state_q   <= S_ORDER;
        end
        S_ORDER: begin
          if (maj0_q > maj1_q) begin
            maj0_q <= maj1_q;
            maj1_q <= maj0_q;
            min0_q <= min1_q;
            min1_q <= min0_q;
          end
          state_q <= S_SETUP;
        end
        S_SETUP: begin
          den_q     <= MAG_W'(dmaj);
          mag_q     <= MAG_W'(dmin_abs);
          neg_q     <= dmin[DIFF_W-1];
          counter_q <= MAJ_W'(maj0_adj >>> COORD_FRAC_BITS);
          limit_q   <= MAJ_W'(maj1_q >>> COORD_FRAC_BITS);
          accum_q   <= ACC_W'(min0_q) <<< ACC_SH;
          state_q   <= S_CHECK;
        end
        S_CHECK: begin
          if (den_q == '0) begin
            slope_q  <= '0;
            active_q <= line_ok;
            state_q  <= S_IDLE;
          end else if (slope_sat) begin
            slope_q  <= neg_q ? -SLOPE_MAX : SLOPE_MAX;
            active_q <= line_ok;
            state_q  <= S_IDLE;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            slope_q  <= quot_signed;
            active_q <= line_ok;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{PAD_W{1'b0}}, out_color_q, out_y_q, out_x_q};
  assign m_axis_tuser_o  = out_in_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && (s_axis_tuser_i == REQ_START)) |=> (!active_q && (state_q == S_AXIS)))
    else $error("Start request did not drop the active line.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_done |=> (state_q == S_IDLE))
    else $error("Sequencer did not finish after the division.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> ((slope_q <= SLOPE_MAX) && (slope_q >= -SLOPE_MAX)))
    else $error("Slope outside its saturation range.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && (s_axis_tuser_i == REQ_STEP) && active_q && last_pix)
      |=> (!active_q && m_axis_tvalid_o && m_axis_tlast_o))
    else $error("Final pixel did not end the line.");
`endif

endmodule

>>> bench/dda_line_rasterizer_unit_test.sv
module dda_line_rasterizer_unit_test;
  import dlr_pkg::*;

  localparam int unsigned COORD_FRAC = 4;
  localparam int unsigned SLOPE_FRAC = 16;
  localparam longint SLOPE_LIMIT = longint'(2) <<< SLOPE_FRAC;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_STEPS_PER_LINE = 40;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} rx_mode_e;

  typedef struct {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [COLOR_W-1:0]     color;
    logic                   on_canvas;
    logic                   is_last;
  } pixel_exp_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_valid;
  cfg_reg_e cfg_index;
  logic [CANVAS_W-1:0] cfg_data;
  logic cfg_ready_o;
  logic s_valid;
  logic s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_data;
  logic s_user;
  logic m_axis_tvalid_o;
  logic m_ready;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;
  logic m_axis_tuser_o;
  logic m_axis_tlast_o;

  pixel_exp_t pending_pixels[$];
  int error_count = 0;
  int quiet_cycles = 0;
  int hold_off_left = 0;
  int burst_left = 0;

  longint canvas_w_model;
  longint canvas_h_model;
  bit     line_on;
  bit     line_steep;
  longint line_pos;
  longint line_stop;
  longint line_minor;
  longint line_slope;
  logic [COLOR_W-1:0] line_color;

  dda_line_rasterizer_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint shift_toward_zero(longint v, int unsigned s);
    return (v < 0) ? -((-v) >>> s) : (v >>> s);
  endfunction

  function automatic logic signed [XY_W-1:0] clamp_xy(longint v);
    if (v > 8191) return 14'h1FFF;
    if (v < -8192) return 14'h2000;
    return v[XY_W-1:0];
  endfunction

  function automatic logic [COORD_W-1:0] clamp_coord(longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[COORD_W-1:0];
  endfunction

  function automatic logic [S_TDATA_W-1:0] pack_line(longint xs, longint ys, longint xe,
                                                     longint ye, logic [COLOR_W-1:0] color);
    return {color, clamp_coord(ye), clamp_coord(xe), clamp_coord(ys), clamp_coord(xs)};
  endfunction

  function automatic logic [S_TDATA_W-1:0] random_payload();
    return {$urandom, $urandom, $urandom};
  endfunction

  // Advances the line state for one request; returns 1 when a pixel is due.
  function automatic bit trace_pixel(logic kind, logic [S_TDATA_W-1:0] payload);
    longint xs, ys, xe, ye, dx_int, dy_int, maj0, maj1, min0, min1, swap, span, rise;
    longint ratio, hw, hh, bx, by;
    pixel_exp_t px;
    if (kind == REQ_START) begin
      xs = longint'($signed(payload[15:0]));
      ys = longint'($signed(payload[31:16]));
      xe = longint'($signed(payload[47:32]));
      ye = longint'($signed(payload[63:48]));
      dx_int = shift_toward_zero((xe > xs) ? xe - xs : xs - xe, COORD_FRAC);
      dy_int = shift_toward_zero((ye > ys) ? ye - ys : ys - ye, COORD_FRAC);
      line_steep = !(dx_int > dy_int);
      if (line_steep) begin
        maj0 = ys; maj1 = ye; min0 = xs; min1 = xe;
      end else begin
        maj0 = xs; maj1 = xe; min0 = ys; min1 = ye;
      end
      if (maj0 > maj1) begin
        swap = maj0; maj0 = maj1; maj1 = swap;
        swap = min0; min0 = min1; min1 = swap;
      end
      span = maj1 - maj0;
      rise = min1 - min0;
      if (span == 0) begin
        ratio = 0;
      end else begin
        ratio = (((rise < 0) ? -rise : rise) <<< SLOPE_FRAC) / span;
        if (rise < 0) ratio = -ratio;
      end
      if (ratio > SLOPE_LIMIT) ratio = SLOPE_LIMIT;
      if (ratio < -SLOPE_LIMIT) ratio = -SLOPE_LIMIT;
      line_slope = ratio;
      line_pos = shift_toward_zero(maj0, COORD_FRAC);
      line_stop = maj1 >>> COORD_FRAC;
      line_minor = min0 * (longint'(1) <<< (SLOPE_FRAC - COORD_FRAC));
      line_color = payload[95:64];
      line_on = line_pos <= line_stop;
      return 1'b0;
    end
    if (!line_on) return 1'b0;
    hw = canvas_w_model >>> 1;
    hh = canvas_h_model >>> 1;
    if (line_steep) begin
      by = hh - line_pos;
      bx = shift_toward_zero(line_minor + (hw <<< SLOPE_FRAC), SLOPE_FRAC);
    end else begin
      bx = line_pos + hw;
      by = shift_toward_zero((hh <<< SLOPE_FRAC) - line_minor, SLOPE_FRAC);
    end
    px.x = clamp_xy(bx);
    px.y = clamp_xy(by);
    px.color = line_color;
    px.on_canvas = (bx >= 0) && (bx < canvas_w_model) && (by >= 0) && (by < canvas_h_model);
    px.is_last = line_pos >= line_stop;
    if (px.is_last) begin
      line_on = 1'b0;
    end else begin
      line_pos++;
      line_minor += line_slope;
    end
    pending_pixels.push_back(px);
    return 1'b1;
  endfunction

  task automatic send_request(input logic kind, input logic [S_TDATA_W-1:0] payload,
                              output bit made_pixel);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        @(negedge clk_i);
        s_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_valid <= 1'b1;
    s_data <= payload;
    s_user <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    made_pixel = trace_pixel(kind, payload);
  endtask

  task automatic send_steps(input int n, inout int produced);
    bit made;
    repeat (n) begin
      send_request(REQ_STEP, random_payload(), made);
      produced++;
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_valid <= 1'b0;
    burst_left = 0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_canvas_reg(input cfg_reg_e idx, input logic [CANVAS_W-1:0] value);
    drain();
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_CANVAS_WIDTH) canvas_w_model = longint'(value);
    else canvas_h_model = longint'(value);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_lines(input int budget);
    int counted;
    int shape;
    int steps;
    longint reach, lenq, xs, ys, xe, ye, remain;
    bit made;
    counted = 0;
    while (counted < budget) begin
      reach = ((canvas_w_model > canvas_h_model) ? canvas_w_model : canvas_h_model) / 2 + 24;
      if (reach > 2047) reach = 2047;
      if ($urandom_range(0, 9) == 0) begin
        // Stray steps, or a start request with arbitrary bits.
        if ($urandom_range(0, 1) == 0) begin
          send_steps($urandom_range(1, 3), counted);
        end else begin
          send_request(REQ_START, random_payload(), made);
          counted++;
          send_steps($urandom_range(0, 5), counted);
        end
      end else begin
        lenq = longint'($urandom_range(0, 400));
        xs = longint'($urandom_range(0, 2 * reach * 16)) - reach * 16;
        ys = longint'($urandom_range(0, 2 * reach * 16)) - reach * 16;
        xe = xs + longint'($urandom_range(0, 2 * lenq)) - lenq;
        ye = ys + longint'($urandom_range(0, 2 * lenq)) - lenq;
        shape = $urandom_range(0, 11);
        if (shape == 0) begin
          xe = xs;
          ye = ys;
        end else if (shape == 1) begin
          ye = ys;
        end else if (shape == 2) begin
          xe = xs;
        end
        send_request(REQ_START, pack_line(xs, ys, xe, ye, $urandom), made);
        counted++;
        remain = line_on ? line_stop - line_pos + 1 : 0;
        if ($urandom_range(0, 3) == 0) steps = $urandom_range(0, int'(remain));
        else steps = int'(remain) + $urandom_range(0, 2);
        if (steps > MAX_STEPS_PER_LINE) steps = MAX_STEPS_PER_LINE;
        send_steps(steps, counted);
      end
    end
  endtask

  task automatic test_directed_cases();
    int produced;
    bit made;
    produced = 0;
    // Step with no line active.
    send_steps(1, produced);
    // Shallow line, one idle step after its end.
    send_request(REQ_START, pack_line(0, 0, 48, 8, 32'h00FF_8800), made);
    send_steps(5, produced);
    // Steep line given end first, so the endpoints are swapped.
    send_request(REQ_START, pack_line(24, 48, -16, -8, 32'h1234_5678), made);
    send_steps(4, produced);
    // Zero length line: slope of zero, a single pixel.
    send_request(REQ_START, pack_line(37, 19, 37, 19, 32'hA5A5_5A5A), made);
    send_steps(1, produced);
    // Empty pixel range: the line never becomes active.
    send_request(REQ_START, pack_line(0, -8, 0, -4, 32'h0F0F_0F0F), made);
    send_steps(1, produced);
    // Slopes that saturate at both signs.
    send_request(REQ_START, pack_line(0, 0, 15, 1, 32'h8000_0001), made);
    send_steps(1, produced);
    send_request(REQ_START, pack_line(0, 0, -15, 1, 32'h7FFF_FFFE), made);
    send_steps(1, produced);
    // Extreme endpoints, abandoned by the next start request.
    send_request(REQ_START, pack_line(-32768, 32767, 32767, -32768, 32'hFFFF_FFFF), made);
    send_steps(2, produced);
    send_request(REQ_START, pack_line(32767, -32768, -32768, 32767, 32'h0000_0000), made);
    send_steps(1, produced);
    drain();
  endtask

  task automatic test_output_stall();
    int produced;
    bit made;
    produced = 0;
    drain();
    send_request(REQ_START, pack_line(-1600, 0, 1600, 80, 32'hC0FF_EE00), made);
    hold_off_left = 300;
    send_steps(40, produced);
    drain();
  endtask

  task automatic test_canvas_sizes();
    logic [CANVAS_W-1:0] widths[8];
    logic [CANVAS_W-1:0] heights[8];
    widths  = '{13'd1, 13'd4096, 13'd0, 13'd640, 13'd4096, 13'd8191, 13'd0, 13'd640};
    heights = '{13'd1, 13'd4096, 13'd480, 13'd0, 13'd1, 13'd4095, 13'd0, 13'd480};
    run_random_lines(100);
    foreach (widths[i]) begin
      write_canvas_reg(REG_CANVAS_WIDTH, widths[i]);
      write_canvas_reg(REG_CANVAS_HEIGHT, heights[i]);
      run_random_lines(100);
    end
    write_canvas_reg(REG_CANVAS_WIDTH, CANVAS_W'($urandom_range(1, 4096)));
    write_canvas_reg(REG_CANVAS_HEIGHT, CANVAS_W'($urandom_range(1, 4096)));
    run_random_lines(100);
    drain();
  endtask

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    pixel_exp_t want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: pixel expected none got tdata %h", $time, m_axis_tdata_o);
        error_count++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("out_x", want.x, $signed(m_axis_tdata_o[13:0]));
        check_field("out_y", want.y, $signed(m_axis_tdata_o[27:14]));
        check_field("out_color", want.color, m_axis_tdata_o[59:28]);
        check_field("tdata fill", 0, m_axis_tdata_o[63:60]);
        check_field("in_canvas", want.on_canvas, m_axis_tuser_o);
        check_field("last_pixel", want.is_last, m_axis_tlast_o);
      end
    end
  end

  always @(negedge clk_i) begin
    rx_mode_e mode;
    int pattern_left;
    int tick;
    tick++;
    if (hold_off_left > 0) begin
      hold_off_left--;
      m_ready <= 1'b0;
    end else begin
      if (pattern_left <= 0) begin
        mode = rx_mode_e'($urandom_range(0, 2));
        pattern_left = $urandom_range(16, 96);
      end
      pattern_left--;
      case (mode)
        RX_ALWAYS: begin
          m_ready <= 1'b1;
        end
        RX_RANDOM: begin
          m_ready <= ($urandom_range(0, 1) == 1);
        end
        default: begin
          m_ready <= (tick % 4 != 0);
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready) ||
        (cfg_valid && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_CANVAS_WIDTH;
    cfg_data = '0;
    s_valid = 1'b0;
    s_data = '0;
    s_user = REQ_START;
    m_ready = 1'b0;
    canvas_w_model = longint'(CANVAS_WIDTH_RESET);
    canvas_h_model = longint'(CANVAS_HEIGHT_RESET);
    line_on = 1'b0;
    line_steep = 1'b0;
    line_pos = 0;
    line_stop = 0;
    line_minor = 0;
    line_slope = 0;
    line_color = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_output_stall();
    test_canvas_sizes();

    drain();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
